// ===== hdl/stkk_pkg.sv =====
// ----------------------------------------------------------------------------
// stkk_pkg: shared types for the sorted top-k keeper
// Entry layout, per-cell control, operation and status codes, FSM states.
// ----------------------------------------------------------------------------
package stkk_pkg;

  localparam int MAX_RESULTS = 16;

  typedef struct packed {
    logic [63:0] mask;
    logic [31:0] weight;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     in_fill;  // cell index is below the fill count
    logic     is_tail;  // cell holds the last valid entry
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    OP_OFFER = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IGNORED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_REJECTED = 3'd2,
    ST_ENTRY    = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

endpackage

// ===== hdl/stkk_cell.sv =====
// ----------------------------------------------------------------------------
// stkk_cell: one slot of the sorted list
// Compares its entry against the candidate and either holds, takes the
// candidate, takes its left neighbor (insert shift) or rotates during read out.
// ----------------------------------------------------------------------------
module stkk_cell
  import stkk_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     cand_i,
  input  entry_t     left_i,
  input  logic       left_before_i,
  input  entry_t     right_i,
  input  entry_t     head_i,
  output logic       before_o,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;
  logic   less;

  // weight first, mask breaks ties
  assign less = (entry_q.weight != cand_i.weight) ? (entry_q.weight < cand_i.weight)
                                                  : (entry_q.mask < cand_i.mask);
  assign before_o = ctrl_i.in_fill && less;

  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      CELL_HOLD: begin
        entry_d = entry_q;
      end
      CELL_INSERT: begin
        if (before_o) begin
          entry_d = entry_q;
        end else if (left_before_i) begin
          entry_d = cand_i;
        end else begin
          entry_d = left_i;
        end
      end
      CELL_ROTATE: begin
        if (ctrl_i.is_tail) begin
          entry_d = head_i;
        end else if (ctrl_i.in_fill) begin
          entry_d = right_i;
        end else begin
          entry_d = entry_q;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== hdl/sorted_top_k_keeper_core.sv =====
// ----------------------------------------------------------------------------
// sorted_top_k_keeper_core: top-k sorted insertion list
// A row of compare-and-shift cells keeps the best candidates in order.
// ----------------------------------------------------------------------------
// Offer and clear: result strobed the cycle after acceptance, and a new
//   transaction can be taken every cycle (busy stays low).
// Read out: the list rotates through cell 0 once, results strobed one per
//   cycle from the cycle after acceptance, busy high while the remaining
//   entries are read. Results cannot be stalled by the receiver.
// Reset (rst_ni low, async): list empty, keep_count 16, no strobe.
module sorted_top_k_keeper_core
  import stkk_pkg::*;
#(
  parameter int MAX_KEEP = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [63:0] candidate_mask_i,
  input  logic [31:0] candidate_weight_i,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  output logic        strobe_o,
  output logic [2:0]  status_o,
  output logic [3:0]  position_o,
  output logic [63:0] entry_mask_o,
  output logic [31:0] entry_weight_o,
  output logic        last_o
);

  localparam int CntW = $clog2(MAX_KEEP + 1);
  localparam int LimW = (CntW > 5) ? CntW : 5;

  state_e          state_q, state_d;
  logic [4:0]      keep_q;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] step_q, step_d, step_cur;
  logic [CntW-1:0] idx;

  logic [LimW-1:0] keep_ext, lim_w, wdata_ext, wlim_w;
  logic [LimW-1:0] fill_ext, idx_ext, nout_w, step_ext;

  entry_t                cand;
  entry_t                cell_q [MAX_KEEP];
  logic   [MAX_KEEP-1:0] ahead;
  cell_ctrl_t            ctrl   [MAX_KEEP];
  cell_op_e              cell_op;

  logic    accept, offer_ok, reject;
  logic    strobe_q, strobe_d, last_q, last_d;
  status_e status_q, status_d;
  logic [3:0] pos_q, pos_d;
  entry_t  res_q, res_d;

  assign cand.mask   = candidate_mask_i;
  assign cand.weight = candidate_weight_i;

  assign busy   = (state_q == S_READ);
  assign accept = start && !busy;

  assign keep_ext  = LimW'(keep_q);
  assign lim_w     = (keep_ext > LimW'(MAX_KEEP)) ? LimW'(MAX_KEEP) : keep_ext;
  assign wdata_ext = LimW'(cfg_wdata_i);
  assign wlim_w    = (wdata_ext > LimW'(MAX_KEEP)) ? LimW'(MAX_KEEP) : wdata_ext;
  assign fill_ext  = LimW'(fill_q);
  assign nout_w    = (fill_ext > LimW'(MAX_RESULTS)) ? LimW'(MAX_RESULTS) : fill_ext;
  assign step_cur  = (state_q == S_IDLE) ? '0 : step_q;
  assign step_ext  = LimW'(step_cur);

  // ahead[] is a prefix of ones; the insert slot is just past its end
  always_comb begin
    idx = '0;
    for (int i = 0; i < MAX_KEEP; i++) begin
      if (ahead[i]) begin
        idx = CntW'(i + 1);
      end
    end
  end
  assign idx_ext = LimW'(idx);

  assign offer_ok = (candidate_mask_i != '0) && (lim_w != '0);
  assign reject   = (fill_ext >= lim_w) && (idx_ext >= lim_w);

  // ---------------------------------------------------------------- cell row
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_b;

    // cell 0 sees a virtual left neighbor that always sorts first
    if (i == 0) begin : g_first
      assign left_e = cell_q[i];
      assign left_b = 1'b1;
    end else begin : g_mid
      assign left_e = cell_q[i-1];
      assign left_b = ahead[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_end
      assign right_e = cell_q[i];
    end else begin : g_nxt
      assign right_e = cell_q[i+1];
    end

    assign ctrl[i].op      = cell_op;
    assign ctrl[i].in_fill = (CntW'(i) < fill_q);
    assign ctrl[i].is_tail = (CntW'(i + 1) == fill_q);

    stkk_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl[i]),
      .cand_i       (cand),
      .left_i       (left_e),
      .left_before_i(left_b),
      .right_i      (right_e),
      .head_i       (cell_q[0]),
      .before_o     (ahead[i]),
      .entry_o      (cell_q[i])
    );
  end

  // -------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (operation_i == OP_READ) && (fill_q > CntW'(1))) begin
          state_d = S_READ;
          step_d  = CntW'(1);
        end
      end
      S_READ: begin
        if (step_q == fill_q - CntW'(1)) begin
          state_d = S_IDLE;
        end else begin
          step_d = step_q + CntW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ----------------------------------------------------------------- outputs
  always_comb begin
    logic do_read;
    do_read  = 1'b0;
    cell_op  = CELL_HOLD;
    fill_d   = fill_q;
    strobe_d = 1'b0;
    status_d = ST_IGNORED;
    pos_d    = '0;
    res_d    = '0;
    last_d   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          strobe_d = 1'b1;
          case (op_e'(operation_i))
            OP_OFFER: begin
              if (!offer_ok) begin
                status_d = ST_IGNORED;
              end else if (reject) begin
                status_d = ST_REJECTED;
              end else begin
                cell_op  = CELL_INSERT;
                status_d = ST_INSERTED;
                pos_d    = 4'(idx);
                if (fill_ext < lim_w) begin
                  fill_d = fill_q + CntW'(1);
                end
              end
            end
            OP_READ: begin
              if (fill_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                do_read = 1'b1;
              end
            end
            OP_CLEAR: begin
              fill_d   = '0;
              status_d = ST_EMPTY;
            end
            default: begin
              status_d = ST_IGNORED;
            end
          endcase
        end
      end
      S_READ: begin
        do_read = 1'b1;
      end
      default: begin
        do_read = 1'b0;
      end
    endcase

    // read out: cell 0 is the current entry, then the valid part rotates
    if (do_read) begin
      cell_op  = CELL_ROTATE;
      strobe_d = (step_ext < nout_w);
      status_d = ST_ENTRY;
      pos_d    = 4'(step_cur);
      res_d    = cell_q[0];
      last_d   = (step_ext == nout_w - LimW'(1));
    end

    // lowering the limit trims the tail of the list
    if (cfg_we_i && (fill_ext > wlim_w)) begin
      fill_d = CntW'(wlim_w);
    end
  end

  // --------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= '0;
      fill_q   <= '0;
      keep_q   <= 5'd16;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      fill_q   <= fill_d;
      strobe_q <= strobe_d;
      if (cfg_we_i) begin
        keep_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    pos_q    <= pos_d;
    res_q    <= res_d;
    last_q   <= last_d;
  end

  assign strobe_o       = strobe_q;
  assign status_o       = status_q;
  assign position_o     = pos_q;
  assign entry_mask_o   = res_q.mask;
  assign entry_weight_o = res_q.weight;
  assign last_o         = last_q;

endmodule

// ===== hdl/stkk_checker.sv =====
// ----------------------------------------------------------------------------
// stkk_checker: port-level checks for the sorted top-k keeper
// Watches transactions and result strobes on the top-level ports.
// ----------------------------------------------------------------------------
module stkk_checker
  import stkk_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  operation_i,
  input logic        strobe_o,
  input logic [2:0]  status_o,
  input logic [3:0]  position_o,
  input logic [63:0] entry_mask_o,
  input logic [31:0] entry_weight_o,
  input logic        last_o
);

  // every accepted transaction shows its first result in the next cycle
  a_first_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> strobe_o)
    else $error("no result after accepted transaction");

  // only list entries carry data and may be followed by more results
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (status_o != ST_ENTRY) |->
      last_o && (entry_mask_o == '0) && (entry_weight_o == '0))
    else $error("non-entry result with data or without last");

  a_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (status_o == ST_IGNORED || status_o == ST_REJECTED ||
                 status_o == ST_EMPTY) |-> (position_o == '0))
    else $error("position set on a result that has none");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (operation_i == OP_CLEAR) |=> (status_o == ST_EMPTY))
    else $error("clear did not report an empty list");

  // while busy stays high during a read out, every strobed result is a list entry
  a_busy_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy && $past(busy) && strobe_o |-> (status_o == ST_ENTRY))
    else $error("non-entry result during read out");

endmodule

bind sorted_top_k_keeper_core stkk_checker u_stkk_checker (.*);
